FILE: rtl/mpq_pkg.sv
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes for the max priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

	localparam int unsigned ValueW = 32;
	localparam int unsigned OccW   = 7;

	typedef logic signed [ValueW-1:0] value_t;

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_REMOVE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// control broadcast to every cell of the row
	typedef struct packed {
		logic   ins;   // insert value (queue not full)
		logic   rem;   // drop the head, shift left (queue not empty)
		value_t value; // value being inserted
	} cell_ctl_t;

endpackage

FILE: rtl/mpq_cmd_if.sv
// ----------------------------------------------------------------------------
// mpq_cmd_if
// Command channel: insert a value or remove the maximum.
// ----------------------------------------------------------------------------
interface mpq_cmd_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [31:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

FILE: rtl/mpq_rsp_if.sv
// ----------------------------------------------------------------------------
// mpq_rsp_if
// Response channel: removed maximum, status and occupancy.
// ----------------------------------------------------------------------------
interface mpq_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] removed_value;
	logic               removed_valid;
	logic [1:0]         status;
	logic [6:0]         occupancy;

	modport source (output valid, output removed_value, output removed_valid,
		output status, output occupancy, input ready);
	modport sink   (input valid, input removed_value, input removed_valid,
		input status, input occupancy, output ready);
endinterface

FILE: rtl/mpq_cell.sv
// ----------------------------------------------------------------------------
// mpq_cell
// One slot of the sorted row; compares against the broadcast value and
// takes its own entry, the broadcast value, or its left or right neighbor's entry.
// ----------------------------------------------------------------------------
module mpq_cell (
	input  logic                clk,
	input  mpq_pkg::cell_ctl_t  ctl,
	input  logic                occ,         // slot holds a stored entry
	input  logic                left_ge,     // left slot keeps its entry on insert
	input  mpq_pkg::value_t     left_value,
	input  mpq_pkg::value_t     right_value,
	output logic                ge,
	output mpq_pkg::value_t     value
);

	mpq_pkg::value_t value_q;

	// equal values stay ahead of the new one
	assign ge    = occ && (value_q >= ctl.value);
	assign value = value_q;

	always_ff @(posedge clk) begin
		if (ctl.ins && !ge) begin
			value_q <= left_ge ? ctl.value : left_value;
		end else if (ctl.rem) begin
			value_q <= right_value;
		end
	end

endmodule

FILE: rtl/max_priority_queue_top.sv
// ----------------------------------------------------------------------------
// max_priority_queue_top
// Max priority queue built as a systolic row of sorted cells.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                            role
//  -------  ---  -------------------------------------------------  -----------
//  cmd      in   action(1), value(32 signed)                         operation
//  rsp      out  removed_value(32 s), removed_valid(1), status(2),   one result
//               occupancy(7)                                         per item
//
//  Rate: one item per clock while the response slot is free or draining. All
//  cells compare against the broadcast value at once and shift together, so
//  the cell row sets the rate. rsp.valid rises the cycle after cmd acceptance.
//  Reset clears the entry count and the response valid; cell contents are
//  left as they are and are never read above the count.
//  Stalls: the response register holds while rsp.ready is low, and cmd.ready
//  drops only while that register is full and not being taken.
//
module max_priority_queue_top #(
	parameter int unsigned CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	mpq_cmd_if.sink    cmd,
	mpq_rsp_if.source  rsp
);

	localparam int unsigned CntW = $clog2(CAPACITY + 1);

	// entry count; the cells carry no valid bits of their own
	logic [CntW-1:0]     count_q;
	logic                rsp_valid_q;
	mpq_pkg::value_t     rsp_value_q;
	logic                rsp_rvalid_q;
	mpq_pkg::status_t    rsp_status_q;
	logic [CntW-1:0]     rsp_count_q;

	logic                accept;
	logic                is_insert;
	logic                full;
	logic                empty;
	mpq_pkg::cell_ctl_t  ctl;

	// row wiring: index 0 holds the maximum
	logic                occ   [CAPACITY];
	logic                ge    [CAPACITY];
	mpq_pkg::value_t     value [CAPACITY];

	// a new item is taken whenever the response slot is free or draining
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign is_insert = (cmd.action == mpq_pkg::ACT_INSERT);
	assign full      = (count_q == CntW'(CAPACITY));
	assign empty     = (count_q == '0);

	always_comb begin
		ctl.ins   = accept && is_insert && !full;
		ctl.rem   = accept && !is_insert && !empty;
		ctl.value = cmd.value;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		mpq_pkg::value_t left_value;
		mpq_pkg::value_t right_value;
		logic            left_ge;

		assign occ[i] = (count_q > CntW'(i));

		if (i == 0) begin : g_head
			assign left_ge    = 1'b1;
			assign left_value = '0;
		end else begin : g_body
			assign left_ge    = ge[i-1];
			assign left_value = value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_value = '0;
		end else begin : g_inner
			assign right_value = value[i+1];
		end

		mpq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.occ         (occ[i]),
			.left_ge     (left_ge),
			.left_value  (left_value),
			.right_value (right_value),
			.ge          (ge[i]),
			.value       (value[i])
		);
	end

	// control: entry count and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctl.ins) begin
				count_q <= count_q + CntW'(1);
			end else if (ctl.rem) begin
				count_q <= count_q - CntW'(1);
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, captured with the operation
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_value_q  <= ctl.rem ? value[0] : '0;
			rsp_rvalid_q <= ctl.rem;
			if (is_insert && full) begin
				rsp_status_q <= mpq_pkg::ST_FULL;
			end else if (!is_insert && empty) begin
				rsp_status_q <= mpq_pkg::ST_EMPTY;
			end else begin
				rsp_status_q <= mpq_pkg::ST_OK;
			end
			if (ctl.ins) begin
				rsp_count_q <= count_q + CntW'(1);
			end else if (ctl.rem) begin
				rsp_count_q <= count_q - CntW'(1);
			end else begin
				rsp_count_q <= count_q;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.removed_value = rsp_value_q;
	assign rsp.removed_valid = rsp_rvalid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.occupancy     = mpq_pkg::OccW'(rsp_count_q);

endmodule
